// ===== rtl/core/four_digit_seven_segment_scan_unit_macros.svh =====
// Assertion shorthands shared by the scan unit. Both expect signals named
// clock and reset in the scope where they are used.
`ifndef FOUR_DIGIT_SEVEN_SEGMENT_SCAN_UNIT_MACROS_SVH
`define FOUR_DIGIT_SEVEN_SEGMENT_SCAN_UNIT_MACROS_SVH

// Same-cycle implication.
`define FDSS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define FDSS_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/fdss_pkg.sv =====
package fdss_pkg;

   localparam int DIGIT_COUNT = 4;
   localparam int MAX_DIGITS  = 4;
   localparam int SCAN_DIGITS = (DIGIT_COUNT < 1) ? 1 :
                                ((DIGIT_COUNT > MAX_DIGITS) ? MAX_DIGITS : DIGIT_COUNT);
   localparam int RESULT_COUNT = 2 * SCAN_DIGITS;
   localparam int STEP_W       = $clog2(RESULT_COUNT);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RESULT_COUNT - 1);

   localparam int VALUE_W = 16;
   localparam int BYTE_W  = 8;

   // Widths of the successive quotients value/10, value/100, value/1000.
   localparam int Q1_W = 13;
   localparam int Q2_W = 10;
   localparam int Q3_W = 7;

   // floor(x / 10) == (x * 52429) >> 19 for every 16-bit x.
   localparam logic [15:0] RECIP_10    = 16'd52429;
   localparam int          RECIP_SHIFT = 19;

   localparam logic [BYTE_W-1:0] SEG_BLANK = 8'h00;

   typedef logic [3:0]              bcd_type;
   typedef bcd_type [MAX_DIGITS-1:0] digit_vec_type;
   typedef logic [BYTE_W-1:0]       port_byte_type;

   function automatic logic [VALUE_W-1:0] div10(input logic [VALUE_W-1:0] x);
      logic [2*VALUE_W-1:0] prod;
      prod = x * RECIP_10;
      return VALUE_W'(prod >> RECIP_SHIFT);
   endfunction

   function automatic bcd_type rem10(input logic [VALUE_W-1:0] x,
                                     input logic [VALUE_W-1:0] q);
      logic [VALUE_W-1:0] r;
      r = x - ((q << 3) + (q << 1));
      return r[3:0];
   endfunction

   // Common-cathode patterns, segment a in bit 0.
   function automatic port_byte_type seg_code(input bcd_type d);
      port_byte_type s;
      case (d)
         4'd0:    s = 8'h3F;
         4'd1:    s = 8'h06;
         4'd2:    s = 8'h5B;
         4'd3:    s = 8'h4F;
         4'd4:    s = 8'h66;
         4'd5:    s = 8'h6D;
         4'd6:    s = 8'h7D;
         4'd7:    s = 8'h07;
         4'd8:    s = 8'h7F;
         4'd9:    s = 8'h6F;
         default: s = SEG_BLANK;
      endcase
      return s;
   endfunction

   // Active-low digit enables, units digit first.
   function automatic port_byte_type select_code(input logic [1:0] i);
      port_byte_type s;
      case (i)
         2'd0:    s = 8'h7F;
         2'd1:    s = 8'hBF;
         2'd2:    s = 8'hDF;
         2'd3:    s = 8'hEF;
         default: s = 8'hFF;
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/core/fdss_if.sv =====
interface fdss_req_if import fdss_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface fdss_rsp_if import fdss_pkg::*; ();
   logic          valid;
   logic          ready;
   port_byte_type digit_enable;
   port_byte_type segments;
   logic          last;

   modport source (output valid, output digit_enable, output segments, output last,
                   input ready);
   modport sink   (input valid, input digit_enable, input segments, input last,
                   output ready);
endinterface

// ===== rtl/core/fdss_digit_split.sv =====
`include "four_digit_seven_segment_scan_unit_macros.svh"

module fdss_digit_split import fdss_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [VALUE_W-1:0] in_value,
   output logic               out_valid,
   input  logic               out_ready,
   output digit_vec_type      out_digits
);

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   logic [Q1_W-1:0] q1_ff, q1_in;
   logic [Q2_W-1:0] q2_ff, q2_in;
   logic [Q3_W-1:0] q3_ff, q3_in;
   logic [VALUE_W-1:0] q1_full, q2_full, q3_full, q4_full;

   bcd_type s1_d0_ff, d0_in;
   bcd_type s2_d0_ff, s2_d1_ff, d1_in;
   bcd_type s3_d0_ff, s3_d1_ff, s3_d2_ff, d2_in;
   bcd_type d3_in;
   digit_vec_type digits_ff;

   // A stage advances when it is empty or the stage after it advances.
   assign en4 = !v4_ff || out_ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign in_ready = en1;

   // One division by ten per stage, done as a reciprocal multiplication.
   always_comb begin
      q1_full = div10(in_value);
      q1_in   = q1_full[Q1_W-1:0];
      d0_in   = rem10(in_value, q1_full);

      q2_full = div10(VALUE_W'(q1_ff));
      q2_in   = q2_full[Q2_W-1:0];
      d1_in   = rem10(VALUE_W'(q1_ff), q2_full);

      q3_full = div10(VALUE_W'(q2_ff));
      q3_in   = q3_full[Q3_W-1:0];
      d2_in   = rem10(VALUE_W'(q2_ff), q3_full);

      q4_full = div10(VALUE_W'(q3_ff));
      d3_in   = rem10(VALUE_W'(q3_ff), q4_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         q1_ff    <= q1_in;
         s1_d0_ff <= d0_in;
      end
      if (en2) begin
         q2_ff    <= q2_in;
         s2_d0_ff <= s1_d0_ff;
         s2_d1_ff <= d1_in;
      end
      if (en3) begin
         q3_ff    <= q3_in;
         s3_d0_ff <= s2_d0_ff;
         s3_d1_ff <= s2_d1_ff;
         s3_d2_ff <= d2_in;
      end
      if (en4) begin
         digits_ff[0] <= s3_d0_ff;
         digits_ff[1] <= s3_d1_ff;
         digits_ff[2] <= s3_d2_ff;
         digits_ff[3] <= d3_in;
      end
   end

   assign out_valid  = v4_ff;
   assign out_digits = digits_ff;

   `FDSS_ASSERT_IMP(a_digits_decimal, v4_ff,
      digits_ff[0] <= 4'd9 && digits_ff[1] <= 4'd9 &&
      digits_ff[2] <= 4'd9 && digits_ff[3] <= 4'd9,
      "digit split produced a non-decimal digit")
   `FDSS_ASSERT_NXT(a_stall_holds, v4_ff && !out_ready,
      v4_ff && $stable(digits_ff), "stalled digits changed")
   `FDSS_ASSERT_IMP(a_ready_when_empty, !v1_ff, in_ready,
      "empty first stage refused a request")

endmodule

// ===== rtl/core/four_digit_seven_segment_scan_unit.sv =====
// Four-digit multiplexed seven-segment scan unit. Each request carries a 16-bit
// number; the unit shows its low four decimal digits and answers with eight
// port writes, units digit first: for each digit the active-low select byte with
// the digit's common-cathode pattern, then the same select byte with a blank
// pattern, and the eighth write carries last. The digits come out of a
// four-stage pipeline that divides by ten once per stage; the first write then
// leaves through the held-number register and the output register. The output
// port delivers one write per cycle while the receiver is ready; the next request
// is already being split while the current number is written out.
`include "four_digit_seven_segment_scan_unit_macros.svh"

module four_digit_seven_segment_scan_unit import fdss_pkg::*; (
   input logic         clock,
   input logic         reset,
   fdss_req_if.sink    req_ch,
   fdss_rsp_if.source  rsp_ch
);

   logic          pipe_valid, pipe_ready;
   digit_vec_type pipe_digits;

   logic              cur_valid_ff, cur_valid_in;
   logic [STEP_W-1:0] step_ff, step_in;
   digit_vec_type     cur_digits_ff;
   logic              out_valid_ff, out_valid_in;
   port_byte_type     sel_ff, seg_ff;
   logic              last_ff;

   logic       load;
   logic       finishing;
   logic [1:0] digit_idx;

   fdss_digit_split u_split (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_ch.valid),
      .in_ready   (req_ch.ready),
      .in_value   (req_ch.value),
      .out_valid  (pipe_valid),
      .out_ready  (pipe_ready),
      .out_digits (pipe_digits)
   );

   assign load      = !out_valid_ff || rsp_ch.ready;
   assign finishing = cur_valid_ff && (step_ff == LAST_STEP) && load;
   assign pipe_ready = !cur_valid_ff || finishing;
   assign digit_idx = 2'(step_ff >> 1);

   always_comb begin
      cur_valid_in = cur_valid_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = cur_valid_ff;
      end
      if (load && cur_valid_ff) begin
         step_in = (step_ff == LAST_STEP) ? '0 : step_ff + 1'b1;
      end
      // The next number moves in as the last write of the current one leaves.
      if (pipe_ready) begin
         cur_valid_in = pipe_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_ready && pipe_valid) begin
         cur_digits_ff <= pipe_digits;
      end
      if (load && cur_valid_ff) begin
         sel_ff  <= select_code(digit_idx);
         seg_ff  <= step_ff[0] ? SEG_BLANK : seg_code(cur_digits_ff[digit_idx]);
         last_ff <= (step_ff == LAST_STEP);
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.digit_enable = sel_ff;
   assign rsp_ch.segments     = seg_ff;
   assign rsp_ch.last         = last_ff;

   `FDSS_ASSERT_IMP(a_mid_scan_held, step_ff != '0, cur_valid_ff,
      "scan position advanced without a number held")
   `FDSS_ASSERT_NXT(a_blank_follows,
      rsp_ch.valid && rsp_ch.ready && rsp_ch.segments != SEG_BLANK,
      rsp_ch.valid, "blanking write did not follow a pattern write")
   `FDSS_ASSERT_IMP(a_select_shape, rsp_ch.valid,
      rsp_ch.digit_enable[3:0] == 4'hF && $onehot(~rsp_ch.digit_enable[7:4]),
      "digit select is not a single active-low enable")

endmodule
